[design/ticket_lock_manager_top_macros.svh]
// Assertion macros for the ticket lock manager.
`ifndef TICKET_LOCK_MANAGER_TOP_MACROS_SVH
`define TICKET_LOCK_MANAGER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TLM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLM_ASSERT(lbl, clk, rst, prop, msg)
`define TLM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[design/tlm_pkg.sv]
`timescale 1ns / 1ps
package tlm_pkg;

   localparam int TICKET_W   = 32;
   localparam int LOCK_REC_W = TICKET_W + 1;
   localparam int COUNT_W    = 5;
   localparam int FUNC_W     = 2;

   localparam logic [COUNT_W-1:0]  NODE_LIMIT_RESET = 5'd16;
   localparam logic [TICKET_W-1:0] TICKET_ALL_ONES  = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ACQUIRE = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_CHECK   = 2'd2,
      FUNC_GRANT   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

[design/ticket_lock_manager_top.sv]
`timescale 1ns / 1ps
// Flow: acquire, release, grant and check on an owned lock pass the lookup and done states;
// check grant on a free lock also walks the node records in the scan state, with one
// 32-bit comparator taking one record per cycle through the node RAM port. No new request
// is taken until the result is loaded. A held result beat delays loading the next one.
// Reset: synchronous, active high; a clearing pass then zeroes the lock RAM one entry a
// cycle with req_stall high, and the node count returns to 16.
`include "ticket_lock_manager_top_macros.svh"
module ticket_lock_manager_top #(
   parameter int LOCKS = 64,
   parameter int NODES = 16,
   localparam int LOCK_W = (LOCKS > 1) ? $clog2(LOCKS) : 1,
   localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [tlm_pkg::COUNT_W-1:0]  csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tlm_pkg::FUNC_W-1:0]   req_func,
   input  logic [NODE_W-1:0]            req_node_id,
   input  logic [LOCK_W-1:0]            req_lock_id,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_status,
   output logic                         rsp_grant_found,
   output logic [NODE_W-1:0]            rsp_grant_node,
   output logic [tlm_pkg::TICKET_W-1:0] rsp_ticket
);

   localparam int CNT_W  = $clog2(NODES + 1);
   localparam int CMPW   = (CNT_W > tlm_pkg::COUNT_W) ? CNT_W : tlm_pkg::COUNT_W;
   localparam int LW1    = LOCK_W + 1;
   localparam int TW     = tlm_pkg::TICKET_W;

   tlm_pkg::state_type state_ff, state_in;
   tlm_pkg::func_type  func_ff, func_in;

   logic [LOCK_W-1:0]           clr_ff, clr_in;
   logic [tlm_pkg::COUNT_W-1:0] node_limit_ff;
   logic [NODE_W-1:0]           node_ff, node_in;
   logic [LOCK_W-1:0]           lock_ff, lock_in;
   logic                        bad_ff, bad_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [NODES-1:0]            active_ff, active_in;
   logic [TW-1:0]               best_ff, best_in;
   logic [CNT_W-1:0]            iss_ff, iss_in;
   logic                        cmp_valid_ff, cmp_valid_in;
   logic [CNT_W-1:0]            cmp_idx_ff, cmp_idx_in;
   logic                        res_status_ff, res_status_in;
   logic                        res_found_ff, res_found_in;
   logic [NODE_W-1:0]           res_node_ff, res_node_in;
   logic [TW-1:0]               res_ticket_ff, res_ticket_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_status_ff;
   logic                        rsp_found_ff;
   logic [NODE_W-1:0]           rsp_node_ff;
   logic [TW-1:0]               rsp_ticket_ff;

   logic                              accept;
   logic                              load_rsp;
   logic                              cmp_hit;
   logic [LOCK_W-1:0]                 lock_idx;
   logic [LW1-1:0]                    lock_ext;
   logic [CMPW-1:0]                   eff_count;
   logic                              lock_we;
   logic [LOCK_W-1:0]                 lock_waddr;
   logic [tlm_pkg::LOCK_REC_W-1:0]    lock_wdata;
   logic [tlm_pkg::LOCK_REC_W-1:0]    lock_rd;
   logic                              node_we;
   logic [NODE_W-1:0]                 node_raddr;
   logic [TW-1:0]                     node_rd;

   tlm_ram #(.WIDTH(tlm_pkg::LOCK_REC_W), .DEPTH(LOCKS)) u_lock_ram (
      .clock   (clock),
      .wr_en   (lock_we),
      .wr_addr (lock_waddr),
      .wr_data (lock_wdata),
      .rd_addr (lock_idx),
      .rd_data (lock_rd)
   );

   tlm_ram #(.WIDTH(TW), .DEPTH(NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_ff),
      .wr_data (lock_rd[TW:1]),
      .rd_addr (node_raddr),
      .rd_data (node_rd)
   );

   assign accept   = req_valid && !req_stall;
   assign lock_ext = LW1'(req_lock_id);
   assign lock_idx = (lock_ext >= LW1'(LOCKS)) ? LOCK_W'(lock_ext - LW1'(LOCKS)) : req_lock_id;
   assign eff_count = (CMPW'(node_limit_ff) > CMPW'(NODES)) ? CMPW'(NODES)
                                                             : CMPW'(node_limit_ff);
   assign cmp_hit  = cmp_valid_ff && active_ff[cmp_idx_ff[NODE_W-1:0]] && (node_rd < best_ff);
   assign load_rsp = (state_ff == tlm_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlm_pkg::ST_CLEAR: begin
            if (clr_ff == LOCK_W'(LOCKS - 1)) begin
               state_in = tlm_pkg::ST_IDLE;
            end
         end
         tlm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = tlm_pkg::ST_LOOKUP;
            end
         end
         tlm_pkg::ST_LOOKUP: begin
            if (func_ff == tlm_pkg::FUNC_CHECK && !lock_rd[0]) begin
               state_in = tlm_pkg::ST_SCAN;
            end else begin
               state_in = tlm_pkg::ST_DONE;
            end
         end
         tlm_pkg::ST_SCAN: begin
            if (iss_ff >= count_ff) begin
               state_in = tlm_pkg::ST_DONE;
            end
         end
         tlm_pkg::ST_DONE: begin
            if (load_rsp) begin
               state_in = tlm_pkg::ST_IDLE;
            end
         end
         default: state_in = tlm_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_stall     = (state_ff != tlm_pkg::ST_IDLE);
      clr_in        = clr_ff;
      func_in       = func_ff;
      node_in       = node_ff;
      lock_in       = lock_ff;
      bad_in        = bad_ff;
      count_in      = count_ff;
      active_in     = active_ff;
      best_in       = best_ff;
      iss_in        = iss_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = iss_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_node_in   = res_node_ff;
      res_ticket_in = res_ticket_ff;
      lock_we       = 1'b0;
      lock_waddr    = lock_ff;
      lock_wdata    = lock_rd;
      node_we       = 1'b0;
      node_raddr    = req_node_id;

      unique case (state_ff)
         tlm_pkg::ST_CLEAR: begin
            lock_we    = 1'b1;
            lock_waddr = clr_ff;
            lock_wdata = '0;
            clr_in     = clr_ff + 1'b1;
         end
         tlm_pkg::ST_IDLE: begin
            func_in  = tlm_pkg::func_type'(req_func);
            node_in  = req_node_id;
            lock_in  = lock_idx;
            count_in = CNT_W'(eff_count);
            bad_in   = (CMPW'(req_node_id) >= eff_count);
         end
         tlm_pkg::ST_LOOKUP: begin
            res_status_in = 1'b0;
            res_found_in  = 1'b0;
            res_node_in   = '0;
            res_ticket_in = '0;
            best_in       = tlm_pkg::TICKET_ALL_ONES;
            iss_in        = '0;
            if (func_ff != tlm_pkg::FUNC_CHECK && bad_ff) begin
               res_status_in = 1'b1;
            end else begin
               unique case (func_ff)
                  tlm_pkg::FUNC_ACQUIRE: begin
                     res_ticket_in      = lock_rd[TW:1];
                     lock_we            = 1'b1;
                     lock_wdata         = {lock_rd[TW:1] + 1'b1, lock_rd[0]};
                     node_we            = 1'b1;
                     active_in[node_ff] = 1'b1;
                  end
                  tlm_pkg::FUNC_RELEASE: begin
                     lock_we            = 1'b1;
                     lock_wdata         = {lock_rd[TW:1], 1'b0};
                     active_in[node_ff] = 1'b0;
                  end
                  tlm_pkg::FUNC_GRANT: begin
                     res_ticket_in = active_ff[node_ff] ? node_rd : '0;
                     lock_we       = 1'b1;
                     lock_wdata    = {lock_rd[TW:1], 1'b1};
                  end
                  tlm_pkg::FUNC_CHECK: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         tlm_pkg::ST_SCAN: begin
            node_raddr = iss_ff[NODE_W-1:0];
            if (iss_ff < count_ff) begin
               cmp_valid_in = 1'b1;
               iss_in       = iss_ff + 1'b1;
            end
         end
         tlm_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase

      if (cmp_hit) begin
         best_in      = node_rd;
         res_found_in = 1'b1;
         res_node_in  = cmp_idx_ff[NODE_W-1:0];
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tlm_pkg::ST_CLEAR;
         clr_ff        <= '0;
         node_limit_ff <= tlm_pkg::NODE_LIMIT_RESET;
         active_ff     <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         active_ff    <= active_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            node_limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      node_ff       <= node_in;
      lock_ff       <= lock_in;
      bad_ff        <= bad_in;
      count_ff      <= count_in;
      best_ff       <= best_in;
      iss_ff        <= iss_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_node_ff   <= res_node_in;
      res_ticket_ff <= res_ticket_in;
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_node_ff   <= res_node_ff;
         rsp_ticket_ff <= res_ticket_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_grant_found = rsp_found_ff;
   assign rsp_grant_node  = rsp_node_ff;
   assign rsp_ticket      = rsp_ticket_ff;

   `TLM_ASSERT(a_beat_from_done, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == tlm_pkg::ST_DONE),
      "result beat raised outside done state")
   `TLM_ASSERT(a_scan_in_range, clock, reset,
      cmp_valid_ff |-> (cmp_idx_ff < count_ff),
      "scan compare beyond node count")
   `TLM_ASSERT(a_found_not_bad, clock, reset,
      rsp_valid |-> !(rsp_status && rsp_grant_found),
      "grant found on an invalid request")
   `TLM_ASSERT(a_none_node_zero, clock, reset,
      (rsp_valid && !rsp_grant_found) |-> (rsp_grant_node == '0),
      "grant node set without a grant")
   `TLM_ASSERT_ALWAYS(a_reset_quiet, clock,
      reset |=> (!rsp_valid && state_ff == tlm_pkg::ST_CLEAR),
      "block not quiet after reset")

endmodule

[design/tlm_ram.sv]
`timescale 1ns / 1ps
module tlm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;

   localparam int LOCKS         = 64;
   localparam int NODES         = 16;
   localparam int ITEM_TARGET   = 1800;
   localparam int PHASE_ITEMS   = 150;
   localparam int QUIET_ITEMS   = 200;
   localparam int SETTLE_CYCLES = 30;

   typedef struct packed {
      bit        status;
      bit        found;
      bit [3:0]  node;
      bit [31:0] ticket;
   } lock_reply_type;

   class lock_grant_tracker;
      bit [31:0]      issue_tick [LOCKS];
      bit [31:0]      serve_tick [LOCKS];
      bit             owner_valid [LOCKS];
      bit [3:0]       holder_node [LOCKS];
      bit [31:0]      node_ticket [NODES];
      bit             node_active [NODES];
      bit [4:0]       node_limit;
      lock_reply_type pending_replies[$];
      lock_reply_type last_reply;
      int             errors;
      int             beats;
      int             check_count;
      int             found_count;

      function new();
         node_limit = tlm_pkg::NODE_LIMIT_RESET;
      endfunction

      function int live_nodes();
         return (node_limit > NODES) ? NODES : node_limit;
      endfunction

      function void note_request(tlm_pkg::func_type f, bit [3:0] nid, bit [5:0] lid);
         lock_reply_type r;
         bit [31:0]      best;
         int             limit;
         limit = live_nodes();
         r = '0;
         if (f == tlm_pkg::FUNC_CHECK) begin
            check_count++;
            if (!owner_valid[lid]) begin
               best = tlm_pkg::TICKET_ALL_ONES;
               for (int i = 0; i < limit; i++) begin
                  if (node_active[i] && node_ticket[i] < best) begin
                     best    = node_ticket[i];
                     r.node  = 4'(i);
                     r.found = 1'b1;
                  end
               end
            end
            if (r.found) found_count++;
         end else if (nid >= limit) begin
            r.status = 1'b1;
         end else begin
            case (f)
               tlm_pkg::FUNC_ACQUIRE: begin
                  r.ticket         = issue_tick[lid];
                  issue_tick[lid]  = r.ticket + 32'd1;
                  node_ticket[nid] = r.ticket;
                  node_active[nid] = 1'b1;
               end
               tlm_pkg::FUNC_RELEASE: begin
                  node_ticket[nid] = '0;
                  node_active[nid] = 1'b0;
                  owner_valid[lid] = 1'b0;
                  holder_node[lid] = '0;
               end
               default: begin
                  r.ticket         = node_ticket[nid];
                  owner_valid[lid] = 1'b1;
                  holder_node[lid] = nid;
                  serve_tick[lid]  = r.ticket;
               end
            endcase
         end
         last_reply = r;
         pending_replies.push_back(r);
      endfunction

      task report_mismatch(string what, longint unsigned want, longint unsigned got);
         $display("MISMATCH beat %0d %s: want 0x%0h got 0x%0h", beats, what, want, got);
         errors++;
      endtask

      task check_reply(lock_reply_type got);
         lock_reply_type want;
         beats++;
         if (pending_replies.size() == 0) begin
            report_mismatch("beat with nothing outstanding", 0, got);
         end else begin
            want = pending_replies.pop_front();
            if (got.status != want.status) report_mismatch("status", want.status, got.status);
            if (got.found != want.found) report_mismatch("grant_found", want.found, got.found);
            if (got.node != want.node) report_mismatch("grant_node", want.node, got.node);
            if (got.ticket != want.ticket) report_mismatch("ticket", want.ticket, got.ticket);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [4:0]  csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [3:0]  req_node_id;
   logic [5:0]  req_lock_id;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_status;
   logic        rsp_grant_found;
   logic [3:0]  rsp_grant_node;
   logic [31:0] rsp_ticket;

   lock_grant_tracker tracker;
   int          item_count;
   int          settings_count;
   bit          quiet;
   bit          send_calm;
   bit          stall_calm;
   int          stall_left;
   logic [5:0]  lock_pool [4];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   ticket_lock_manager_top #(
      .LOCKS(LOCKS),
      .NODES(NODES)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_node_id    (req_node_id),
      .req_lock_id    (req_lock_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_grant_found(rsp_grant_found),
      .rsp_grant_node (rsp_grant_node),
      .rsp_ticket     (rsp_ticket)
   );

   always @(negedge clock) begin
      if (reset || quiet || stall_calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 4);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_reply({rsp_status, rsp_grant_found, rsp_grant_node, rsp_ticket});
   end

   task automatic send_request(tlm_pkg::func_type f, logic [3:0] nid, logic [5:0] lid);
      @(negedge clock);
      if (!quiet && !send_calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= f;
      req_node_id <= nid;
      req_lock_id <= lid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(f, nid, lid);
      item_count++;
   endtask

   task automatic drain_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_limit(logic [4:0] value);
      drain_replies();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tracker.node_limit = value;
      settings_count++;
   endtask

   function automatic logic [3:0] pick_node();
      int limit;
      limit = tracker.live_nodes();
      if (limit == 0 || $urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(0, limit - 1));
   endfunction

   function automatic logic [5:0] pick_lock();
      if ($urandom_range(0, 3) != 0) return lock_pool[$urandom_range(0, 3)];
      return 6'($urandom_range(0, LOCKS - 1));
   endfunction

   task automatic run_round();
      logic [5:0] lid;
      logic [3:0] winner;
      lid = pick_lock();
      repeat ($urandom_range(1, 4)) send_request(tlm_pkg::FUNC_ACQUIRE, pick_node(), lid);
      send_request(tlm_pkg::FUNC_CHECK, 4'($urandom_range(0, 15)), lid);
      if (tracker.last_reply.found) begin
         winner = tracker.last_reply.node;
         send_request(tlm_pkg::FUNC_GRANT, winner, lid);
         if ($urandom_range(0, 2) == 0)
            send_request(tlm_pkg::FUNC_CHECK, 4'($urandom_range(0, 15)), lid);
         if ($urandom_range(0, 5) != 0) send_request(tlm_pkg::FUNC_RELEASE, winner, lid);
      end
   endtask

   initial begin
      logic [4:0] plan [12];
      int         phase;
      int         phase_end;
      tracker     = new();
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_func    = tlm_pkg::FUNC_ACQUIRE;
      req_node_id = '0;
      req_lock_id = '0;
      plan = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd2, 5'd17, 5'd12, 5'd16, 5'd5, 5'd16};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(tlm_pkg::FUNC_CHECK, 4'hF, 6'd0);
      send_request(tlm_pkg::FUNC_ACQUIRE, 4'd0, 6'd0);
      send_request(tlm_pkg::FUNC_ACQUIRE, 4'd15, 6'd63);
      send_request(tlm_pkg::FUNC_ACQUIRE, 4'd5, 6'd0);
      send_request(tlm_pkg::FUNC_CHECK, 4'h0, 6'd0);
      send_request(tlm_pkg::FUNC_GRANT, 4'd0, 6'd0);
      send_request(tlm_pkg::FUNC_CHECK, 4'hA, 6'd0);
      send_request(tlm_pkg::FUNC_RELEASE, 4'd7, 6'd0);
      send_request(tlm_pkg::FUNC_CHECK, 4'h5, 6'd0);
      send_request(tlm_pkg::FUNC_GRANT, 4'd9, 6'd42);
      send_request(tlm_pkg::FUNC_RELEASE, 4'd0, 6'd63);
      send_request(tlm_pkg::FUNC_CHECK, 4'h3, 6'd63);
      send_request(tlm_pkg::FUNC_ACQUIRE, 4'd10, 6'd21);
      write_node_limit(5'd4);
      send_request(tlm_pkg::FUNC_ACQUIRE, 4'd4, 6'd0);
      send_request(tlm_pkg::FUNC_GRANT, 4'd15, 6'd1);
      send_request(tlm_pkg::FUNC_RELEASE, 4'd12, 6'd2);
      send_request(tlm_pkg::FUNC_CHECK, 4'h0, 6'd1);
      write_node_limit(5'd0);
      send_request(tlm_pkg::FUNC_ACQUIRE, 4'd0, 6'd0);
      send_request(tlm_pkg::FUNC_CHECK, 4'hF, 6'd2);
      write_node_limit(5'd31);
      send_request(tlm_pkg::FUNC_ACQUIRE, 4'd15, 6'd0);
      send_request(tlm_pkg::FUNC_CHECK, 4'h0, 6'd3);
      write_node_limit(5'd1);
      send_request(tlm_pkg::FUNC_ACQUIRE, 4'd1, 6'd7);
      send_request(tlm_pkg::FUNC_ACQUIRE, 4'd0, 6'd7);
      send_request(tlm_pkg::FUNC_CHECK, 4'h6, 6'd7);

      phase = 0;
      while (item_count < ITEM_TARGET) begin
         write_node_limit((phase < 12) ? plan[phase] : 5'($urandom_range(1, 16)));
         foreach (lock_pool[i]) lock_pool[i] = 6'($urandom_range(0, LOCKS - 1));
         send_calm  = ($urandom_range(0, 4) == 0);
         stall_calm = ($urandom_range(0, 4) == 0);
         phase_end  = item_count + PHASE_ITEMS;
         while (item_count < phase_end && item_count < ITEM_TARGET) begin
            if (item_count >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
            if ($urandom_range(0, 9) < 7)
               run_round();
            else
               send_request(tlm_pkg::func_type'($urandom_range(0, 3)),
                            pick_node(), pick_lock());
         end
         phase++;
      end

      drain_replies();
      $display("tb: %0d requests over %0d node limits; %0d check grants, %0d picked a waiter",
               item_count, settings_count, tracker.check_count, tracker.found_count);
      $display("tb: %0d result beats compared, %0d mismatches", tracker.beats, tracker.errors);
      if (tracker.errors == 0 && tracker.pending_replies.size() == 0)
         $display("ticket_lock_manager_top: match");
      else
         $display("ticket_lock_manager_top: mismatch");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("ticket_lock_manager_top: mismatch");
      $finish;
   end

endmodule
